/* sv/gww_pkg.sv */
package gww_pkg;

  // field widths
  localparam int unsigned WidthW  = 16;
  localparam int unsigned CharW   = 8;
  localparam int unsigned GlyphW  = 8;
  localparam int unsigned SpaceW  = 8;
  localparam int unsigned SpcW    = 5;
  localparam int unsigned CountW  = 8;
  localparam int unsigned AccW    = 17;

  // character that separates words
  localparam logic [CharW-1:0] SEPARATOR = 8'd32;

  // line count at which the overflow flag is raised
  localparam logic [CountW-1:0] LINE_BOUND = 8'd32;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_WIDTH    = 2'd0;
  localparam logic [1:0] REG_CHAR_SPACING = 2'd1;
  localparam logic [1:0] REG_SPACE_WIDTH  = 2'd2;

  // configuration reset values
  localparam logic [WidthW-1:0] MAX_WIDTH_RST    = 16'd640;
  localparam logic [SpcW-1:0]   CHAR_SPACING_RST = 5'd0;
  localparam logic [SpaceW-1:0] SPACE_WIDTH_RST  = 8'd8;

  // output queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = 2;
  localparam int unsigned FifoCntW  = 3;

  // configuration seen by the wrap logic
  typedef struct packed {
    logic [WidthW-1:0] max_width;
    logic [SpcW-1:0]   char_spacing;
    logic [SpaceW-1:0] space_width;
  } cfg_t;

  // one emitted line
  typedef struct packed {
    logic              too_many_lines;
    logic [WidthW-1:0] widest_width;
    logic              last_line;
    logic [CountW-1:0] line_number;
    logic [WidthW-1:0] line_chars;
    logic [WidthW-1:0] line_width;
  } res_t;

  // which results a step pushes into the queue
  typedef struct packed {
    logic spill;
    logic fin;
  } push_t;

endpackage

/* sv/gww_regs.sv */
module gww_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output gww_pkg::cfg_t        cfg_o
);

  logic [gww_pkg::WidthW-1:0] max_width_q;
  logic [gww_pkg::SpcW-1:0]   char_spacing_q;
  logic [gww_pkg::SpaceW-1:0] space_width_q;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes, index from the word address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q    <= gww_pkg::MAX_WIDTH_RST;
      char_spacing_q <= gww_pkg::CHAR_SPACING_RST;
      space_width_q  <= gww_pkg::SPACE_WIDTH_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        gww_pkg::REG_MAX_WIDTH:    max_width_q    <= pwdata[15:0];
        gww_pkg::REG_CHAR_SPACING: char_spacing_q <= pwdata[4:0];
        gww_pkg::REG_SPACE_WIDTH:  space_width_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      gww_pkg::REG_MAX_WIDTH:    prdata = {16'd0, max_width_q};
      gww_pkg::REG_CHAR_SPACING: prdata = {27'd0, char_spacing_q};
      gww_pkg::REG_SPACE_WIDTH:  prdata = {24'd0, space_width_q};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o.max_width    = max_width_q;
  assign cfg_o.char_spacing = char_spacing_q;
  assign cfg_o.space_width  = space_width_q;

endmodule

/* sv/gww_core.sv */
module gww_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gww_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [gww_pkg::CharW-1:0]   char_code_i,
  input  logic [gww_pkg::GlyphW-1:0]  glyph_width_i,
  input  logic                        end_of_text_i,
  input  logic                        room_i,
  output gww_pkg::push_t              push_o,
  output gww_pkg::res_t               res_a_o,
  output gww_pkg::res_t               res_b_o
);

  // input register
  logic                       in_vld_q;
  logic [gww_pkg::CharW-1:0]  code_q;
  logic [gww_pkg::GlyphW-1:0] glyph_q;
  logic                       end_q;
  logic                       adv;

  // sentence state
  logic [gww_pkg::WidthW-1:0] cur_w_q, cur_w_d;
  logic [gww_pkg::WidthW-1:0] cur_c_q, cur_c_d;
  logic [gww_pkg::AccW-1:0]   acc_q, acc_d;
  logic [gww_pkg::WidthW-1:0] wc_q, wc_d;
  logic                       first_q, first_d;
  logic [gww_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [gww_pkg::WidthW-1:0] wid_q, wid_d;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign adv        = in_vld_q & room_i;
  assign in_ready_o = ~in_vld_q | room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      code_q  <= char_code_i;
      glyph_q <= glyph_width_i;
      end_q   <= end_of_text_i;
    end
  end

  // one character step
  always_comb begin
    logic                       is_sep, close, fits, spill;
    logic signed [18:0]         cs_x, a, wdiff, need, sum;
    logic [gww_pkg::AccW-1:0]   acc_sat, acc_new;
    logic [gww_pkg::WidthW-1:0] wc_new, ww, cur_w1, cur_c1, wid1, wid2;
    logic [gww_pkg::CountW-1:0] cnt1;

    is_sep = (code_q == gww_pkg::SEPARATOR);
    close  = is_sep | end_q;
    cs_x   = {{14{cfg_i.char_spacing[4]}}, cfg_i.char_spacing};

    // running word width, saturated to the 17 bit signed range
    a = {{2{acc_q[16]}}, acc_q} + $signed({11'd0, glyph_q}) + cs_x;
    if (a > 19'sd65535) begin
      acc_sat = 17'h0FFFF;
    end else if (a < -19'sd65536) begin
      acc_sat = 17'h10000;
    end else begin
      acc_sat = a[16:0];
    end
    acc_new = is_sep ? acc_q : acc_sat;
    wc_new  = is_sep ? wc_q : sat_add16(wc_q, 16'd1);

    // closed word width without trailing spacing
    wdiff = {{2{acc_new[16]}}, acc_new} - cs_x;
    if (wdiff < 19'sd0) begin
      ww = 16'd0;
    end else if (wdiff > 19'sd65535) begin
      ww = 16'hFFFF;
    end else begin
      ww = wdiff[15:0];
    end

    // join test in full signed precision
    need = $signed({11'd0, cfg_i.space_width}) + (cs_x <<< 1) + $signed({3'd0, ww});
    sum  = $signed({3'd0, cur_w_q}) + need;
    fits = (sum <= $signed({3'd0, cfg_i.max_width}));
    spill = close & ~first_q & ~fits;

    // line state after the word closes
    cur_w1 = cur_w_q;
    cur_c1 = cur_c_q;
    if (close) begin
      if (first_q || spill) begin
        cur_w1 = ww;
        cur_c1 = wc_new;
      end else begin
        cur_w1 = (sum < 19'sd0) ? 16'd0 : sum[15:0];
        cur_c1 = sat_add16(cur_c_q, sat_add16(wc_new, 16'd1));
      end
    end

    wid1 = (cur_w_q > wid_q) ? cur_w_q : wid_q;
    if (!spill) begin
      wid1 = wid_q;
    end
    cnt1 = cnt_q;
    if (spill && cnt_q != 8'hFF) begin
      cnt1 = cnt_q + 8'd1;
    end
    wid2 = (cur_w1 > wid1) ? cur_w1 : wid1;

    // spilled line
    res_a_o.line_width     = cur_w_q;
    res_a_o.line_chars     = cur_c_q;
    res_a_o.line_number    = cnt_q;
    res_a_o.last_line      = 1'b0;
    res_a_o.widest_width   = wid1;
    res_a_o.too_many_lines = (cnt_q >= gww_pkg::LINE_BOUND);

    // last line of the sentence
    res_b_o.line_width     = cur_w1;
    res_b_o.line_chars     = cur_c1;
    res_b_o.line_number    = cnt1;
    res_b_o.last_line      = 1'b1;
    res_b_o.widest_width   = wid2;
    res_b_o.too_many_lines = (cnt1 >= gww_pkg::LINE_BOUND);

    push_o.spill = adv & spill;
    push_o.fin   = adv & end_q;

    // next state, cleared after the final character
    if (end_q) begin
      cur_w_d = '0;
      cur_c_d = '0;
      acc_d   = '0;
      wc_d    = '0;
      first_d = 1'b1;
      cnt_d   = '0;
      wid_d   = '0;
    end else begin
      cur_w_d = cur_w1;
      cur_c_d = cur_c1;
      acc_d   = close ? '0 : acc_new;
      wc_d    = close ? '0 : wc_new;
      first_d = first_q & ~close;
      cnt_d   = cnt1;
      wid_d   = wid1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_w_q <= '0;
      cur_c_q <= '0;
      acc_q   <= '0;
      wc_q    <= '0;
      first_q <= 1'b1;
      cnt_q   <= '0;
      wid_q   <= '0;
    end else if (adv) begin
      cur_w_q <= cur_w_d;
      cur_c_q <= cur_c_d;
      acc_q   <= acc_d;
      wc_q    <= wc_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      wid_q   <= wid_d;
    end
  end

endmodule

/* sv/gww_fifo.sv */
module gww_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gww_pkg::push_t push_i,
  input  gww_pkg::res_t  res_a_i,
  input  gww_pkg::res_t  res_b_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gww_pkg::res_t  out_res_o
);

  gww_pkg::res_t                 mem_q [gww_pkg::FifoDepth];
  logic [gww_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [gww_pkg::FifoCntW-1:0]  cnt_q;
  logic [gww_pkg::FifoCntW-1:0]  n_push;
  logic [gww_pkg::PtrW-1:0]      wr_ptr_1;
  logic                          pop;
  gww_pkg::res_t                 first_res;

  // two free entries are needed for a step that spills and ends
  assign room_o      = (cnt_q <= gww_pkg::FifoCntW'(gww_pkg::FifoDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign n_push      = {2'd0, push_i.spill} + {2'd0, push_i.fin};
  assign wr_ptr_1    = wr_ptr_q + 2'd1;
  assign first_res   = push_i.spill ? res_a_i : res_b_i;

  // entry writes, spilled line first
  always_ff @(posedge clk_i) begin
    if (push_i.spill || push_i.fin) begin
      mem_q[wr_ptr_q] <= first_res;
    end
    if (push_i.spill && push_i.fin) begin
      mem_q[wr_ptr_1] <= res_b_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_push[gww_pkg::PtrW-1:0];
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_q + n_push - {2'd0, pop};
    end
  end

endmodule

/* sv/greedy_word_wrap.sv */
// greedy word wrap, one character per transaction
// a line closed by a character passes the input register and the output queue before it is offered
// throughput: a character per cycle with queue room; up to two lines each, one per cycle
// the output queue holds four lines and stalls input when fewer than two entries are free
// reset: asynchronous active low, clears the wrap state and queue, config to defaults
module greedy_word_wrap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // char_code [7:0], glyph_width [15:8]
  input  logic        s_axis_tlast,  // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_width [15:0], line_chars [31:16], line_number [39:32], widest_width [55:40]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,  // last_line
  output logic        m_axis_tuser   // too_many_lines
);

  gww_pkg::cfg_t  cfg;
  gww_pkg::push_t push;
  gww_pkg::res_t  res_a, res_b, out_res;
  logic           room;

  // configuration registers
  gww_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // wrap step
  gww_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .char_code_i   (s_axis_tdata[7:0]),
    .glyph_width_i (s_axis_tdata[15:8]),
    .end_of_text_i (s_axis_tlast),
    .room_i        (room),
    .push_o        (push),
    .res_a_o       (res_a),
    .res_b_o       (res_b)
  );

  // line queue
  gww_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_a_i     (res_a),
    .res_b_i     (res_b),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.widest_width, out_res.line_number,
                         out_res.line_chars, out_res.line_width};
  assign m_axis_tlast = out_res.last_line;
  assign m_axis_tuser = out_res.too_many_lines;

endmodule

/* sv/gww_checker.sv */
module gww_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a stalled line stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("line dropped while stalled");

  // a stalled line keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("line payload changed while stalled");

  // overflow flag follows the line number
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[39:32] >= gww_pkg::LINE_BOUND)))
    else $error("overflow flag does not match line number");

  // widest width covers the current line
  a_widest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[55:40] >= m_axis_tdata[15:0]))
    else $error("widest width below line width");

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/wrap_line_checker.sv */
`timescale 1ns / 1ps

// watches the config port and both streams, predicts every emitted line and compares
module wrap_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // char_code [7:0], glyph_width [15:8]
  input  logic        s_axis_tlast,  // end_of_text
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_width [15:0], line_chars [31:16], line_number [39:32], widest_width [55:40]
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,  // last_line
  input  logic        m_axis_tuser,  // too_many_lines
  output int          fail_count_o,
  output int          pending_o,
  output int          lines_seen_o
);

  // register copies
  logic [gww_pkg::WidthW-1:0]      max_width_q;
  logic signed [gww_pkg::SpcW-1:0] spacing_q;
  logic [gww_pkg::SpaceW-1:0]      space_w_q;

  // wrap state
  logic [gww_pkg::WidthW-1:0]      line_w_q;
  logic [gww_pkg::WidthW-1:0]      line_chars_q;
  logic signed [gww_pkg::AccW-1:0] word_acc_q;
  logic [gww_pkg::WidthW-1:0]      word_chars_q;
  logic                            first_word_q;
  logic [gww_pkg::CountW-1:0]      line_cnt_q;
  logic [gww_pkg::WidthW-1:0]      widest_q;

  // lines predicted but not yet seen on the output
  gww_pkg::res_t expected_lines[$];

  function automatic logic [gww_pkg::WidthW-1:0] clamp16(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[gww_pkg::WidthW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    fail_count_o++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("line %0d %s: got %0d, expected %0d",
                                lines_seen_o, name, got, want));
  endtask

  task automatic clear_wrap();
    line_w_q     = '0;
    line_chars_q = '0;
    word_acc_q   = '0;
    word_chars_q = '0;
    first_word_q = 1'b1;
    line_cnt_q   = '0;
    widest_q     = '0;
  endtask

  task automatic emit_line(logic is_last);
    gww_pkg::res_t r;
    if (line_w_q > widest_q) widest_q = line_w_q;
    r.line_width     = line_w_q;
    r.line_chars     = line_chars_q;
    r.line_number    = line_cnt_q;
    r.last_line      = is_last;
    r.widest_width   = widest_q;
    r.too_many_lines = (line_cnt_q >= gww_pkg::LINE_BOUND);
    expected_lines.push_back(r);
  endtask

  // one character of the sentence
  task automatic wrap_char(logic [gww_pkg::CharW-1:0] code,
                           logic [gww_pkg::GlyphW-1:0] glyph, logic eot);
    int sp;
    int acc;
    int need;
    logic [gww_pkg::WidthW-1:0] ww;
    sp = spacing_q;
    if (code != gww_pkg::SEPARATOR) begin
      acc = int'(word_acc_q) + int'(glyph) + sp;
      if (acc > 65535) acc = 65535;
      if (acc < -65536) acc = -65536;
      word_acc_q   = acc[gww_pkg::AccW-1:0];
      word_chars_q = clamp16(int'(word_chars_q) + 1);
    end
    // word closes on a separator or on the final character
    if (code == gww_pkg::SEPARATOR || eot) begin
      ww = clamp16(int'(word_acc_q) - sp);
      if (first_word_q) begin
        line_w_q     = ww;
        line_chars_q = word_chars_q;
        first_word_q = 1'b0;
      end else begin
        need = int'(space_w_q) + 2 * sp + int'(ww);
        if (int'(line_w_q) + need <= int'(max_width_q)) begin
          line_w_q     = clamp16(int'(line_w_q) + need);
          line_chars_q = clamp16(int'(line_chars_q) + int'(clamp16(int'(word_chars_q) + 1)));
        end else begin
          emit_line(1'b0);
          if (line_cnt_q != 8'hFF) line_cnt_q++;
          line_w_q     = ww;
          line_chars_q = word_chars_q;
        end
      end
      word_acc_q   = '0;
      word_chars_q = '0;
    end
    if (eot) begin
      emit_line(1'b1);
      clear_wrap();
    end
  endtask

  task automatic check_line();
    gww_pkg::res_t want;
    if (expected_lines.size() == 0) begin
      report_mismatch($sformatf("line with no expectation, tdata %h", m_axis_tdata));
    end else begin
      want = expected_lines.pop_front();
      check_field("line_width", m_axis_tdata[15:0], want.line_width);
      check_field("line_chars", m_axis_tdata[31:16], want.line_chars);
      check_field("line_number", m_axis_tdata[39:32], want.line_number);
      check_field("widest_width", m_axis_tdata[55:40], want.widest_width);
      check_field("last_line", m_axis_tlast, want.last_line);
      check_field("too_many_lines", m_axis_tuser, want.too_many_lines);
    end
    lines_seen_o++;
  endtask

  // sample every transaction at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q = gww_pkg::MAX_WIDTH_RST;
      spacing_q   = gww_pkg::CHAR_SPACING_RST;
      space_w_q   = gww_pkg::SPACE_WIDTH_RST;
      clear_wrap();
      expected_lines.delete();
      fail_count_o = 0;
      lines_seen_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_line();
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          gww_pkg::REG_MAX_WIDTH:    max_width_q = pwdata[gww_pkg::WidthW-1:0];
          gww_pkg::REG_CHAR_SPACING: spacing_q   = pwdata[gww_pkg::SpcW-1:0];
          gww_pkg::REG_SPACE_WIDTH:  space_w_q   = pwdata[gww_pkg::SpaceW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        wrap_char(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast);
    end
    pending_o = expected_lines.size();
  end

endmodule

/* tb/sv/greedy_word_wrap_tb.sv */
`timescale 1ns / 1ps

module greedy_word_wrap_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomChars = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // char_code [7:0], glyph_width [15:8]
  logic        s_axis_tlast = 1'b0;  // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // line_width [15:0], line_chars [31:16], line_number [39:32], widest_width [55:40]
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;  // last_line
  logic        m_axis_tuser;  // too_many_lines

  int fail_count;
  int pending;
  int lines_seen;
  int chars_sent = 0;
  int settings_used = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  bit paused_mid = 1'b0;

  greedy_word_wrap dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  wrap_line_checker checker_i (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .lines_seen_o(lines_seen)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 17);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d lines pending",
                 stall_cycles, pending);
        $display("[greedy_word_wrap] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_char(logic [7:0] code, logic [7:0] glyph, logic eot);
    while (!no_idle && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {glyph, code};
    s_axis_tlast  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  // hold the sender until every predicted line is out
  task automatic drain_lines();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // new register setting once the block is idle, upper data bits random
  task automatic apply_setting(logic [15:0] mw, logic [4:0] sp, logic [7:0] sw);
    logic [31:0] v;
    drain_lines();
    repeat (4) @(posedge clk_i);
    v = $urandom;
    v[15:0] = mw;
    cfg_write(gww_pkg::REG_MAX_WIDTH, v);
    v = $urandom;
    v[4:0] = sp;
    cfg_write(gww_pkg::REG_CHAR_SPACING, v);
    v = $urandom;
    v[7:0] = sw;
    cfg_write(gww_pkg::REG_SPACE_WIDTH, v);
    settings_used++;
  endtask

  function automatic logic [7:0] word_letter();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(97, 122));
    c = 8'($urandom_range(0, 255));
    if (c == gww_pkg::SEPARATOR) c = 8'd33;
    return c;
  endfunction

  function automatic logic [7:0] pick_glyph(int max_glyph);
    if ($urandom_range(0, 19) == 0) return 8'hFF;
    return 8'($urandom_range(0, max_glyph));
  endfunction

  // well-formed sentence with random words, occasionally broken by noise
  task automatic send_sentence(int words, int max_len, int max_glyph);
    int len;
    bit end_on_space;
    logic is_last;
    end_on_space = $urandom_range(0, 1);
    for (int w = 0; w < words; w++) begin
      if ($urandom_range(0, 9) == 0) len = 0;
      else len = $urandom_range(1, max_len);
      for (int c = 0; c < len; c++) begin
        is_last = (w == words - 1) && (c == len - 1) && !end_on_space;
        if (!is_last && $urandom_range(0, 19) == 0)
          send_char(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        send_char(word_letter(), pick_glyph(max_glyph), is_last);
      end
      if (w < words - 1 || end_on_space || len == 0)
        send_char(gww_pkg::SEPARATOR, 8'($urandom_range(0, 255)), w == words - 1);
      if (w < words - 1 && (!paused_mid || $urandom_range(0, 39) == 0)) begin
        drain_lines();
        paused_mid = 1'b1;
      end
    end
  endtask

  task automatic send_noise();
    int k;
    logic [7:0] code;
    k = $urandom_range(1, 12);
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 3) == 0) code = gww_pkg::SEPARATOR;
      else code = 8'($urandom_range(0, 255));
      send_char(code, 8'($urandom_range(0, 255)), i == k - 1);
    end
  endtask

  task automatic pick_setting();
    logic [15:0] mw;
    logic [4:0] sp;
    logic [7:0] sw;
    case ($urandom_range(0, 3))
      0: mw = 16'd0;
      1: mw = 16'hFFFF;
      default: mw = 16'($urandom_range(24, 320));
    endcase
    case ($urandom_range(0, 9))
      0: sp = 5'h18;
      1: sp = 5'd8;
      2: sp = 5'($urandom);
      default: sp = 5'(int'($urandom_range(0, 16)) - 8);
    endcase
    case ($urandom_range(0, 3))
      0: sw = 8'd0;
      1: sw = 8'hFF;
      default: sw = 8'($urandom_range(0, 16));
    endcase
    apply_setting(mw, sp, sw);
  endtask

  initial begin
    int base;
    int phase;
    int n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: leading space, double space, end on letter and on space
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'd65, 8'hFF, 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'hFF, 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'hFF, 8'hFF, 1'b0);
    send_char(8'd0, 8'd0, 1'b1);
    send_char(gww_pkg::SEPARATOR, 8'd7, 1'b1);
    send_char(8'd1, 8'd128, 1'b1);

    // zero width, negative spacing: negative joins and a spill with the last line
    apply_setting(16'd0, 5'h18, 8'd0);
    send_char(8'd120, 8'd3, 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'd121, 8'd20, 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'd122, 8'd1, 1'b1);

    // widest setting, unused register index written too
    apply_setting(16'hFFFF, 5'd8, 8'hFF);
    cfg_write(REG_UNUSED, $urandom);
    send_char(8'd109, 8'd200, 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'd110, 8'hFF, 1'b1);

    // word long enough to saturate its width, then a spilled word, with no idling
    no_idle <= 1'b1;
    for (int i = 0; i < 260; i++) send_char(word_letter(), 8'($urandom_range(250, 255)), 1'b0);
    send_char(gww_pkg::SEPARATOR, 8'd0, 1'b0);
    send_char(8'd113, 8'hFF, 1'b1);
    no_idle <= 1'b0;

    // every word spills: line count runs past the bound
    apply_setting(16'd0, 5'd0, 8'd0);
    for (int i = 0; i < 40; i++) begin
      send_char(word_letter(), 8'($urandom_range(1, 255)), i == 39);
      if (i < 39) send_char(gww_pkg::SEPARATOR, 8'($urandom_range(0, 255)), 1'b0);
    end

    // random phases, one of them without any idling
    base = chars_sent;
    phase = 0;
    while (chars_sent - base < RandomChars) begin
      pick_setting();
      no_idle <= (phase == 2);
      n = $urandom_range(2, 5);
      for (int s = 0; s < n; s++) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        else send_sentence($urandom_range(1, 8), $urandom_range(1, 6),
                           ($urandom_range(0, 4) == 0) ? 255 : 24);
      end
      phase++;
    end
    no_idle <= 1'b0;

    drain_lines();
    repeat (8) @(posedge clk_i);
    $display("sent %0d characters under %0d register settings, %0d lines compared",
             chars_sent, settings_used, lines_seen);
    $display("included a saturated word, a sentence past the line bound and noise bursts");
    if (fail_count == 0) begin
      $display("[greedy_word_wrap] OK");
    end else begin
      $display("[greedy_word_wrap] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gww_pkg.sv
sv/gww_regs.sv
sv/gww_core.sv
sv/gww_fifo.sv
sv/greedy_word_wrap.sv
sv/gww_checker.sv
tb/sv/wrap_line_checker.sv
tb/sv/greedy_word_wrap_tb.sv
